// File: rtl/uer_pkg.sv
// Shared constants, types and byte translation for the terminal echo ring.
package uer_pkg;

    localparam int unsigned UER_RING_DEPTH = 256;

    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_DEL = 8'd127;

    // Controller to datapath commands
    typedef struct packed {
        logic take;   // latch request, first ring write
        logic wr;     // further ring write of the translated sequence
        logic rd;     // empty check, ring read, flag update
        logic load;   // move result into the response register
    } uer_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic take_more;  // request at the port needs more than one write
        logic wr_last;    // current write is the last of the sequence
        logic out_free;   // response register can take a result now
    } uer_status_t;

    function automatic logic [1:0] xlat_len(input logic [7:0] b);
        logic [1:0] n;
        unique case (b)
            CH_CR:   n = 2'd2;
            CH_DEL:  n = 2'd3;
            default: n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] xlat_byte(input logic [7:0] b, input logic [1:0] idx);
        logic [7:0] c;
        unique case (b)
            CH_CR:   c = (idx == 2'd0) ? CH_NL : CH_CR;
            CH_DEL:  c = (idx == 2'd1) ? CH_SP : CH_BS;
            default: c = b;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/uer_ram.sv
// Generic single-write, single-read RAM with registered read data.
module uer_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/uer_ctrl.sv
// Sequencer: request intake, translated writes, ring read, response load.
module uer_ctrl import uer_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  uer_status_t status,
    output uer_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WR   = 4'b0010,
        ST_RD   = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = status.take_more ? ST_WR : ST_RD;
                end
            end
            ST_WR:
            begin
                cmd.wr = 1'b1;
                if (status.wr_last)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/uer_dp.sv
// Datapath: ring pointers, byte ring, interrupt flag and response register.
module uer_dp import uer_pkg::*; #(
    parameter int unsigned RING_DEPTH = UER_RING_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  uer_cmd_t    cmd,
    output uer_status_t status,
    input  logic        rx_valid,
    input  logic [7:0]  rx_byte,
    input  logic        tx_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        tx_irq_enable
);

    localparam int unsigned PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] rp_reg;
    logic             irq_reg;
    logic [7:0]       byte_reg;
    logic             tx_ready_reg;
    logic [1:0]       idx_reg;
    logic             sent_reg;
    logic             rsp_valid_reg;
    logic             tx_valid_reg;
    logic [7:0]       tx_byte_reg;
    logic             irq_out_reg;

    logic             ram_wr_en;
    logic [7:0]       ram_wr_data;
    logic             ring_empty;
    logic             fire;
    logic [7:0]       ram_rd_data;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign ring_empty = (rp_reg == wp_reg);
    assign fire       = cmd.rd && tx_ready_reg && !ring_empty;

    // first write comes straight from the request port
    assign ram_wr_en   = (cmd.take && rx_valid) || cmd.wr;
    assign ram_wr_data = cmd.take ? xlat_byte(rx_byte, 2'd0) : xlat_byte(byte_reg, idx_reg);

    assign status.take_more = rx_valid && (xlat_len(rx_byte) != 2'd1);
    assign status.wr_last   = (idx_reg == (xlat_len(byte_reg) - 2'd1));
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

    uer_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (ram_wr_data),
        .rd_en   (fire),
        .rd_addr (rp_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            irq_reg       <= 1'b0;
            idx_reg       <= '0;
            sent_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_wr_en)
            begin
                wp_reg <= ptr_inc(wp_reg);
            end
            if (cmd.take)
            begin
                idx_reg <= 2'd1;
                if (rx_valid)
                begin
                    irq_reg <= 1'b1;
                end
            end
            else if (cmd.wr)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (cmd.rd)
            begin
                sent_reg <= fire;
                if (fire)
                begin
                    rp_reg <= ptr_inc(rp_reg);
                end
                else if (tx_ready_reg)
                begin
                    irq_reg <= 1'b0;
                end
            end
            if (cmd.load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            byte_reg     <= rx_byte;
            tx_ready_reg <= tx_ready;
        end
        if (cmd.load)
        begin
            tx_valid_reg <= sent_reg;
            tx_byte_reg  <= sent_reg ? ram_rd_data : 8'd0;
            irq_out_reg  <= irq_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign tx_valid      = tx_valid_reg;
    assign tx_byte       = tx_byte_reg;
    assign tx_irq_enable = irq_out_reg;

endmodule

// File: rtl/uart_echo_ring_buffer.sv
// Top level of the terminal echo ring: controller, datapath and checks.
//
// Each request carries an optional received byte and a transmitter-ready flag
// and yields exactly one response. A received byte goes into a RING_DEPTH-entry
// byte ring (return expands to newline+return, delete to backspace, space,
// backspace) and sets the transmit interrupt enable; then, if the transmitter
// is ready, the oldest ring byte is returned, or the enable is cleared when the
// ring is empty. One request is in flight at a time: a return or a delete
// takes more ring writes than a plain byte, since the ring has a single
// write port (one translated byte per cycle), and its read is registered.
// The response sits in an output register, so a new request is taken
// while an earlier response waits; it completes once that slot frees. Writes
// never check for room: an overrun overwrites old data, and a ring that wraps
// onto its read point looks empty. The ring needs no clearing after reset.
module uart_echo_ring_buffer import uer_pkg::*; #(
    parameter int unsigned RING_DEPTH = UER_RING_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic       rx_valid,
    input  logic [7:0] rx_byte,
    input  logic       tx_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       tx_irq_enable
);

    uer_cmd_t    cmd;
    uer_status_t status;

    uer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    uer_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_valid      (rx_valid),
        .rx_byte       (rx_byte),
        .tx_ready      (tx_ready),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .tx_irq_enable (tx_irq_enable)
    );

    // one request at a time: intake closes right after a request is taken
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in flight");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> rsp_valid)
        else $error("loaded response not presented");

    // a response that carries a sent byte always has the enable set
    a_sent_implies_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && tx_valid) |-> tx_irq_enable)
        else $error("byte sent with interrupt enable clear");

    a_load_only_idle_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> req_ready)
        else $error("intake not reopened after response load");

endmodule

// File: tb/testbench.sv
// Scoreboard-based testbench for the terminal echo ring.
module testbench;
    import uer_pkg::*;

    localparam int unsigned N_REQS         = 1550;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned LONG_HOLD      = 240;
    localparam int unsigned MAX_REPORTS    = 100;

    typedef enum int unsigned {PH_MIX, PH_FILL, PH_DRAIN} phase_t;

    typedef struct packed {
        logic       sent;
        logic [7:0] data;
        logic       irq;
    } echo_rsp_t;

    // Tracks the echo ring and queues the response due for each request.
    class echo_scoreboard;
        logic [7:0]  ring [UER_RING_DEPTH];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        logic        irq_en;
        echo_rsp_t   expected_q[$];
        int          errors;

        function new();
            wr_ptr = 0;
            rd_ptr = 0;
            irq_en = 1'b0;
            errors = 0;
        endfunction

        function void put_byte(logic [7:0] b);
            ring[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1) % UER_RING_DEPTH;
        endfunction

        function void note_request(logic rxv, logic [7:0] rxb, logic txr);
            echo_rsp_t r;
            r = '0;
            if (rxv)
            begin
                if (rxb == CH_CR)
                begin
                    put_byte(CH_NL);
                    put_byte(CH_CR);
                end
                else if (rxb == CH_DEL)
                begin
                    put_byte(CH_BS);
                    put_byte(CH_SP);
                    put_byte(CH_BS);
                end
                else
                begin
                    put_byte(rxb);
                end
                irq_en = 1'b1;
            end
            if (txr)
            begin
                // pointers equal means empty, even after an overrun
                if (rd_ptr != wr_ptr)
                begin
                    r.sent = 1'b1;
                    r.data = ring[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % UER_RING_DEPTH;
                end
                else
                begin
                    irq_en = 1'b0;
                end
            end
            r.irq = irq_en;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("testbench: mismatch: %s", msg);
            errors++;
        endtask

        task check_response(logic v, logic [7:0] b, logic irq);
            echo_rsp_t e;
            if (expected_q.size() == 0)
            begin
                report("response with no request outstanding");
                return;
            end
            e = expected_q.pop_front();
            if (v !== e.sent)
                report($sformatf("tx_valid %b, expected %b", v, e.sent));
            if (b !== e.data)
                report($sformatf("tx_byte %h, expected %h", b, e.data));
            if (irq !== e.irq)
                report($sformatf("tx_irq_enable %b, expected %b", irq, e.irq));
        endtask
    endclass

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic       rx_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'd0;
    logic       tx_ready  = 1'b0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_irq_enable;

    echo_scoreboard sb = new();

    int unsigned n_req      = 0;
    int unsigned quiet_cnt  = 0;
    bit          no_idle    = 1'b0;
    bit          gappy      = 1'b0;
    bit          hold_req   = 1'b0;
    int unsigned stall_left = 0;
    int unsigned run_left   = 0;

    uart_echo_ring_buffer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .rx_valid      (rx_valid),
        .rx_byte       (rx_byte),
        .tx_ready      (tx_ready),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .tx_irq_enable (tx_irq_enable)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            sb.check_response(tx_valid, tx_byte, tx_irq_enable);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cnt = 0;
        else
            quiet_cnt++;
        if (quiet_cnt >= WATCHDOG_LIMIT)
        begin
            $display("testbench: timeout, no handshake for %0d cycles", quiet_cnt);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Response side: random stall bursts, free-running stretches, one long hold.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
                run_left   = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                rsp_ready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(0, 20);
                rsp_ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return CH_CR;
            1:       return CH_DEL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_req(input logic rxv, input logic [7:0] rxb, input logic txr);
        @(negedge clk);
        req_valid <= 1'b1;
        rx_valid  <= rxv;
        rx_byte   <= rxb;
        tx_ready  <= txr;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(rxv, rxb, txr);
        n_req++;
    endtask

    task automatic idle_gap(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    task automatic offer(input logic rxv, input logic [7:0] rxb, input logic txr);
        if (gappy && !no_idle && $urandom_range(0, 7) == 0)
            idle_gap($urandom_range(1, 11));
        send_req(rxv, rxb, txr);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        phase_t      ph;
        int unsigned len;
        logic [7:0]  b;
        bit          held;
        bit          wrapped;
        bit          paused;

        held    = 1'b0;
        wrapped = 1'b0;
        paused  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty ring, byte extremes, both expansions, ignored byte
        send_req(1'b0, 8'h00, 1'b0);
        send_req(1'b0, 8'hFF, 1'b1);
        send_req(1'b1, 8'h00, 1'b0);
        send_req(1'b1, 8'hFF, 1'b1);
        send_req(1'b0, 8'h00, 1'b1);
        send_req(1'b0, 8'h00, 1'b1);
        send_req(1'b1, CH_CR, 1'b1);
        send_req(1'b0, 8'h00, 1'b1);
        send_req(1'b0, 8'h00, 1'b1);
        send_req(1'b1, CH_DEL, 1'b0);
        send_req(1'b0, 8'hFF, 1'b1);
        send_req(1'b0, 8'hFF, 1'b1);
        send_req(1'b0, 8'hFF, 1'b1);
        send_req(1'b0, 8'hFF, 1'b1);
        send_req(1'b1, 8'h41, 1'b1);
        send_req(1'b0, CH_CR, 1'b0);
        send_req(1'b0, CH_DEL, 1'b1);
        send_req(1'b1, 8'h55, 1'b0);
        send_req(1'b1, 8'hAA, 1'b1);
        send_req(1'b0, 8'h00, 1'b0);
        send_req(1'b0, 8'h00, 1'b1);
        send_req(1'b0, 8'h00, 1'b1);

        while (n_req < N_REQS)
        begin
            if (n_req >= 1400)
                no_idle = 1'b1;
            gappy = ($urandom_range(0, 2) != 0);

            if (!wrapped && n_req >= 700)
            begin
                // empty the ring, then write exactly one lap so it wraps onto the read point
                wrapped = 1'b1;
                while (sb.wr_ptr != sb.rd_ptr)
                    offer(1'b0, 8'($urandom_range(0, 255)), 1'b1);
                repeat (UER_RING_DEPTH)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_CR || b == CH_DEL)
                        b = 8'h41;
                    offer(1'b1, b, 1'b0);
                end
                offer(1'b0, 8'($urandom_range(0, 255)), 1'b1);
                continue;
            end

            if (!paused && n_req >= 1000)
            begin
                paused = 1'b1;
                wait_drained();
            end

            // long receiver hold while requests keep coming
            if (!held && n_req >= 400)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
            end

            ph = phase_t'($urandom_range(0, 2));
            case (ph)
                PH_FILL:  len = $urandom_range(150, 320);
                PH_DRAIN: len = $urandom_range(50, 300);
                default:  len = $urandom_range(20, 80);
            endcase
            repeat (len)
            begin
                if (n_req >= N_REQS)
                    break;
                case (ph)
                    PH_FILL:  offer($urandom_range(0, 9) != 0, pick_byte(),
                                    $urandom_range(0, 9) == 0);
                    PH_DRAIN: offer($urandom_range(0, 9) == 0, pick_byte(),
                                    $urandom_range(0, 9) != 0);
                    default:  offer(1'($urandom_range(0, 1)), pick_byte(),
                                    1'($urandom_range(0, 1)));
                endcase
            end
        end

        wait_drained();
        repeat (12) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: files.f
rtl/uer_pkg.sv
rtl/uer_ram.sv
rtl/uer_ctrl.sv
rtl/uer_dp.sv
rtl/uart_echo_ring_buffer.sv
tb/testbench.sv
